// ===== rtl/dtbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtbp_pkg
// Shared types and constants for the DNA two-bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtbp_pkg;

  // Fixed field widths
  localparam int CHAR_W   = 8;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 6;
  localparam int LENGTH_W = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_UC_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_UC_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_UC_T = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_LC_C = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_LC_G = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_LC_T = 8'h74;
  localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;

  // Two-bit base codes (A and anything unknown map to CODE_A)
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Reset value of the trim register
  localparam logic [LENGTH_W-1:0] TRIM_RESET = 16'hFFFF;

  // One result word
  typedef struct packed {
    logic [WORD_W-1:0]   packed_word;
    logic [COUNT_W-1:0]  bases_in_word;
    logic                last_word;
    logic [LENGTH_W-1:0] read_length;
  } result_t;

  // Results produced by one item (second only valid with first)
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  // ASCII to base code
  function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
    logic [1:0] code;
    unique case (c)
      CHAR_UC_C, CHAR_LC_C: code = CODE_C;
      CHAR_UC_G, CHAR_LC_G: code = CODE_G;
      CHAR_UC_T, CHAR_LC_T: code = CODE_T;
      default:              code = CODE_A;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dtbp_ifs.sv =====
// ----------------------------------------------------------------------------
// dtbp channel interfaces
// Valid/ready channels for characters, result words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

// Character channel
interface dtbp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       end_of_read;

  modport source(output valid, base_char, end_of_read, input ready);
  modport sink(input valid, base_char, end_of_read, output ready);
endinterface

// Packed word channel
interface dtbp_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_word;
  logic [5:0]  bases_in_word;
  logic        last_word;
  logic [15:0] read_length;

  modport source(output valid, packed_word, bases_in_word, last_word, read_length,
                 input ready);
  modport sink(input valid, packed_word, bases_in_word, last_word, read_length,
               output ready);
endinterface

// Configuration write channel (trim length)
interface dtbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] trim_length;

  modport source(output valid, trim_length, input ready);
  modport sink(input valid, trim_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtbp_pack.sv =====
// ----------------------------------------------------------------------------
// dtbp_pack
// Input register plus packing state: maps characters to codes, fills the
// word accumulator and produces up to two result words per item.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_pack
  import dtbp_pkg::*;
#(
  parameter int BASES_PER_WORD  = 32,
  parameter int MAX_READ_LENGTH = 65535
) (
  input  wire logic                clk,
  input  wire logic                rst,
  dtbp_char_if.sink                chars,
  input  wire logic [LENGTH_W-1:0] trim_length,
  input  wire logic                room,
  output push_t                    push
);

  localparam int ACC_W = 2 * BASES_PER_WORD;
  localparam int HW    = $clog2(BASES_PER_WORD + 1);
  localparam logic [HW-1:0]       BPW_C = HW'(BASES_PER_WORD);
  localparam logic [LENGTH_W-1:0] MAX_C = LENGTH_W'(MAX_READ_LENGTH);

  // Input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_end;
  logic              adv;

  // Packing state
  logic [ACC_W-1:0]    acc;
  logic [HW-1:0]       held;
  logic [LENGTH_W-1:0] kept;

  logic [LENGTH_W-1:0] limit;
  logic                keep;
  logic                emit_full;
  logic [ACC_W-1:0]    acc_a, acc_next;
  logic [HW-1:0]       held_a, held_next;
  logic [LENGTH_W-1:0] kept_next;
  logic [HW-1:0]       pad_bases;
  logic [HW:0]         shamt;
  logic [ACC_W-1:0]    final_word;
  result_t             full_res, final_res;

  assign adv         = in_valid && room;
  assign chars.ready = !in_valid || room;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
    if (chars.valid && chars.ready) begin
      in_char <= chars.base_char;
      in_end  <= chars.end_of_read;
    end
  end

  // Keep decision
  assign limit     = (trim_length < MAX_C) ? trim_length : MAX_C;
  assign keep      = (in_char != CHAR_LF) && (in_char != CHAR_CR) && (kept < limit);
  assign emit_full = keep && (held == BPW_C);

  // Accumulate the kept base
  always_comb begin
    acc_a     = emit_full ? '0 : acc;
    held_a    = emit_full ? '0 : held;
    acc_next  = acc_a;
    held_next = held_a;
    kept_next = kept;
    if (keep) begin
      acc_next  = {acc_a[ACC_W-3:0], base_code(in_char)};
      held_next = held_a + HW'(1);
      kept_next = kept + LENGTH_W'(1);
    end
  end

  // Left-justify the last word
  assign pad_bases  = BPW_C - held_next;
  assign shamt      = {pad_bases, 1'b0};
  assign final_word = acc_next << shamt;

  always_comb begin
    full_res.packed_word   = WORD_W'(acc);
    full_res.bases_in_word = COUNT_W'(BPW_C);
    full_res.last_word     = 1'b0;
    full_res.read_length   = '0;
    final_res.packed_word   = WORD_W'(final_word);
    final_res.bases_in_word = COUNT_W'(held_next);
    final_res.last_word     = 1'b1;
    final_res.read_length   = kept_next;
  end

  // Result hand-off to the output queue
  always_comb begin
    push.v0 = adv && (emit_full || in_end);
    push.v1 = adv && emit_full && in_end;
    push.r0 = emit_full ? full_res : final_res;
    push.r1 = final_res;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
      kept <= '0;
    end else if (adv) begin
      if (in_end) begin
        acc  <= '0;
        held <= '0;
        kept <= '0;
      end else begin
        acc  <= acc_next;
        held <= held_next;
        kept <= kept_next;
      end
    end
  end

  // Checks
  a_held_range: assert property (@(posedge clk) disable iff (rst) held <= BPW_C)
    else $error("dtbp_pack: bases held beyond word size");
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && !push.r0.last_word && push.r1.last_word))
    else $error("dtbp_pack: bad double result");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && in_end) |=> (held == '0 && kept == '0))
    else $error("dtbp_pack: state not cleared after end of read");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> room)
    else $error("dtbp_pack: push without room");

endmodule

`default_nettype wire

// ===== rtl/dtbp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// dtbp_result_fifo
// Four-entry result queue; takes up to two results a cycle, sends one while words.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_result_fifo
  import dtbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  dtbp_word_if.source words
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  result_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;
  logic [CW-1:0]  push_n;
  result_t        head;

  assign pop    = words.valid && words.ready;
  assign push_n = CW'(push.v0) + CW'(push.v1);
  assign room   = count <= ROOM_MAX;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + push_n - CW'(pop);
    end
  end

  // Head of queue to the port
  assign head                = mem[rd_ptr];
  assign words.valid         = count != '0;
  assign words.packed_word   = head.packed_word;
  assign words.bases_in_word = head.bases_in_word;
  assign words.last_word     = head.last_word;
  assign words.read_length   = head.read_length;

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("dtbp_result_fifo: overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push_n == '0 && !pop) |=> $stable(count))
    else $error("dtbp_result_fifo: count moved without transfer");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> (count <= ROOM_MAX))
    else $error("dtbp_result_fifo: push into full queue");

endmodule

`default_nettype wire

// ===== rtl/dna_two_bit_packer.sv =====
// ----------------------------------------------------------------------------
// dna_two_bit_packer
// Packs a character stream of DNA reads into 2-bit codes, 32 bases per word.
//
//   channel  dir  payload
//   chars    in   base_char[7:0], end_of_read
//   words    out  packed_word[63:0], bases_in_word[5:0], last_word,
//                 read_length[15:0]
//   cfg      in   trim_length[15:0] (always ready)
//
// One character per cycle sustained while the result queue has room; each
// result passes through the input register, then the result queue.
// The rate is set by the four-entry result queue: chars.ready drops while a
// character waits in the input register and the queue holds more than two
// words, since one character can yield two words.
// Reset clears the packing state and queue and sets trim_length to 65535.
// Stalls on words never drop results; the queue drains in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_two_bit_packer
  import dtbp_pkg::*;
#(
  parameter int BASES_PER_WORD  = 32,
  parameter int MAX_READ_LENGTH = 65535
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dtbp_char_if.sink   chars,
  dtbp_word_if.source words,
  dtbp_cfg_if.sink    cfg
);

  logic [LENGTH_W-1:0] trim_length;
  logic                room;
  push_t               push;

  // Trim length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_length <= TRIM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      trim_length <= cfg.trim_length;
    end
  end

  // Packing stage
  dtbp_pack #(
    .BASES_PER_WORD (BASES_PER_WORD),
    .MAX_READ_LENGTH(MAX_READ_LENGTH)
  ) u_pack (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .trim_length(trim_length),
    .room       (room),
    .push       (push)
  );

  // Result queue
  dtbp_result_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .words(words)
  );

endmodule

`default_nettype wire

// ===== tb/dna_two_bit_packer_test.sv =====
// ----------------------------------------------------------------------------
// dna_two_bit_packer_test
// Self-checking bench for the two-bit DNA packer. A directed read covers
// every letter in both cases, dropped line breaks, unknown and high bytes and
// empty reads. Random reads follow, mostly well formed with some noise, over
// several trim lengths from 0 to 65535. A scoreboard predicts each packed
// word and checks every word transfer in order.
// ----------------------------------------------------------------------------
module dna_two_bit_packer_test;
  import dtbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 4;

  // Letters not named in the package
  localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UC_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_LC_N = 8'h6E;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eor;
  } char_item_t;

  logic clk = 1'b0;
  logic rst;

  dtbp_char_if char_ch();
  dtbp_word_if word_ch();
  dtbp_cfg_if  cfg_ch();

  dna_two_bit_packer DUT (
    .clk  (clk),
    .rst  (rst),
    .chars(char_ch),
    .words(word_ch),
    .cfg  (cfg_ch)
  );

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t char_pending[$];
  result_t    word_expect[$];

  int chars_queued   = 0;
  int chars_accepted = 0;
  int mismatches     = 0;
  int stall_cycles   = 0;
  int idle_odds      = 0;
  int src_gap        = 0;
  int sink_gap       = 0;

  // Packer state mirrored by the scoreboard
  logic [WORD_W-1:0] acc_word = '0;
  int                held_cnt = 0;
  int                kept_cnt = 0;
  int                trim_len = int'(TRIM_RESET);

  // Work out the words that one accepted character produces
  function automatic void pack_char(input logic [CHAR_W-1:0] ch, input logic eor);
    logic [1:0] code;
    result_t    r;
    if (ch != CHAR_LF && ch != CHAR_CR && kept_cnt < trim_len) begin
      // a full word goes out only once another kept base shows up
      if (held_cnt == 32) begin
        r.packed_word   = acc_word;
        r.bases_in_word = 6'd32;
        r.last_word     = 1'b0;
        r.read_length   = '0;
        word_expect.push_back(r);
        acc_word = '0;
        held_cnt = 0;
      end
      case (ch)
        CHAR_UC_C, CHAR_LC_C: code = CODE_C;
        CHAR_UC_G, CHAR_LC_G: code = CODE_G;
        CHAR_UC_T, CHAR_LC_T: code = CODE_T;
        default:              code = CODE_A;
      endcase
      acc_word = {acc_word[WORD_W-3:0], code};
      held_cnt++;
      kept_cnt++;
    end
    if (eor) begin
      // final word is left-justified and zero padded
      r.packed_word   = (held_cnt == 0) ? '0 : acc_word << (WORD_W - 2 * held_cnt);
      r.bases_in_word = COUNT_W'(held_cnt);
      r.last_word     = 1'b1;
      r.read_length   = LENGTH_W'(kept_cnt);
      word_expect.push_back(r);
      acc_word = '0;
      held_cnt = 0;
      kept_cnt = 0;
    end
  endfunction

  // Character driver
  always @(posedge clk) begin : char_driver
    char_item_t nxt;
    if (rst) begin
      char_ch.valid <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        pack_char(char_ch.base_char, char_ch.end_of_read);
        chars_accepted++;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          char_ch.valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          src_gap = $urandom_range(0, 15);
          char_ch.valid <= 1'b0;
        end else if (char_pending.size() != 0) begin
          nxt = char_pending.pop_front();
          char_ch.valid       <= 1'b1;
          char_ch.base_char   <= nxt.ch;
          char_ch.end_of_read <= nxt.eor;
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor, sink stalls and stall counter
  always @(posedge clk) begin : word_monitor
    result_t got;
    result_t want;
    if (rst) begin
      word_ch.ready <= 1'b0;
      stall_cycles  <= 0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        got.packed_word   = word_ch.packed_word;
        got.bases_in_word = word_ch.bases_in_word;
        got.last_word     = word_ch.last_word;
        got.read_length   = word_ch.read_length;
        if (word_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: word=%h bases=%0d last=%b len=%0d",
                     got.packed_word, got.bases_in_word, got.last_word, got.read_length);
        end else begin
          want = word_expect.pop_front();
          if (got.packed_word !== want.packed_word || got.bases_in_word !== want.bases_in_word
              || got.last_word !== want.last_word || got.read_length !== want.read_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: exp word=%h bases=%0d last=%b len=%0d, got word=%h bases=%0d last=%b len=%0d",
                       want.packed_word, want.bases_in_word, want.last_word, want.read_length,
                       got.packed_word, got.bases_in_word, got.last_word, got.read_length);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        word_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        sink_gap = $urandom_range(0, 15);
        word_ch.ready <= 1'b0;
      end else begin
        word_ch.ready <= 1'b1;
      end
      if ((char_ch.valid && char_ch.ready) || (word_ch.valid && word_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: no transfer of any kind for too long
  initial begin : watchdog
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("dna_two_bit_packer verification failed");
    $finish;
  end

  task automatic tick();
    @(posedge clk);
    #1;
  endtask

  task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic eor);
    char_item_t it;
    it.ch  = ch;
    it.eor = eor;
    char_pending.push_back(it);
    chars_queued++;
  endtask

  function automatic logic [CHAR_W-1:0] random_letter();
    case ($urandom_range(0, 7))
      0:       return CH_UC_A;
      1:       return CH_LC_A;
      2:       return CHAR_UC_C;
      3:       return CHAR_LC_C;
      4:       return CHAR_UC_G;
      5:       return CHAR_LC_G;
      6:       return CHAR_UC_T;
      default: return CHAR_LC_T;
    endcase
  endfunction

  // Well-formed read: mostly letters, some line breaks and odd bytes
  task automatic queue_read(input int n_chars);
    logic [CHAR_W-1:0] ch;
    int unsigned       pick;
    for (int i = 0; i < n_chars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        ch = random_letter();
      else if (pick < 88)
        ch = ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR;
      else
        ch = CHAR_W'($urandom_range(0, 255));
      queue_char(ch, i == n_chars - 1);
    end
  endtask

  // Wait until every character is in and every word is out
  task automatic drain();
    do tick(); while (chars_accepted != chars_queued || word_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_trim(input int value);
    @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.trim_length <= LENGTH_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    trim_len = value;
    #1;
  endtask

  // Random reads with some noise, closed by a read end so the block is idle
  task automatic run_phase(input int n_items, input int odds);
    int          start;
    int unsigned pick;
    idle_odds = odds;
    start = chars_queued;
    while (chars_queued - start < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 16)
        queue_read($urandom_range(1, 80));
      else if (pick < 18)
        queue_read($urandom_range(60, 160));
      else
        repeat ($urandom_range(1, 8))
          queue_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
    queue_char(random_letter(), 1'b1);
    drain();
  endtask

  // Stimulus
  initial begin : stimulus
    int odds_menu[3];
    odds_menu = '{0, 4, 20};
    rst                 = 1'b1;
    char_ch.valid       = 1'b0;
    char_ch.base_char   = '0;
    char_ch.end_of_read = 1'b0;
    word_ch.ready       = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.trim_length  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed read: all letters, line breaks, unknown and high bytes
    idle_odds = 0;
    queue_char(CH_UC_A, 1'b0);
    queue_char(CHAR_UC_C, 1'b0);
    queue_char(CHAR_UC_G, 1'b0);
    queue_char(CHAR_UC_T, 1'b0);
    queue_char(CH_LC_A, 1'b0);
    queue_char(CHAR_LC_C, 1'b0);
    queue_char(CHAR_LC_G, 1'b0);
    queue_char(CHAR_LC_T, 1'b0);
    queue_char(CHAR_LF, 1'b0);
    queue_char(CH_UC_N, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(CHAR_CR, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(CHAR_UC_T, 1'b1);
    // empty read ended by a line break
    queue_char(CHAR_LF, 1'b1);
    // read ended by a dropped carriage return
    queue_char(CHAR_UC_G, 1'b0);
    queue_char(CHAR_LC_C, 1'b0);
    queue_char(CHAR_CR, 1'b1);
    // single unknown base
    queue_char(CH_LC_N, 1'b1);
    queue_char(8'h7F, 1'b1);
    drain();

    // Zero trim keeps nothing
    write_trim(0);
    queue_char(CH_UC_A, 1'b0);
    queue_char(CHAR_UC_C, 1'b1);
    drain();

    // Random phases over a spread of trim lengths
    run_phase(210, odds_menu[$urandom_range(0, 2)]);
    write_trim(0);
    run_phase(200, odds_menu[$urandom_range(0, 2)]);
    write_trim(1);
    run_phase(200, odds_menu[$urandom_range(0, 2)]);
    write_trim(32);
    run_phase(210, odds_menu[$urandom_range(0, 2)]);
    write_trim(33);
    run_phase(210, odds_menu[$urandom_range(0, 2)]);
    write_trim(31);
    run_phase(200, odds_menu[$urandom_range(0, 2)]);
    write_trim(64);
    run_phase(210, odds_menu[$urandom_range(0, 2)]);
    write_trim($urandom_range(2, 200));
    run_phase(210, odds_menu[$urandom_range(0, 2)]);
    // last stretch at full length with no idling
    write_trim(65535);
    run_phase(200, 0);

    if (word_expect.size() != 0)
      $display("%0d expected words never arrived", word_expect.size());
    if (mismatches == 0 && word_expect.size() == 0) begin
      $display("dna_two_bit_packer verification clean");
    end else begin
      $display("dna_two_bit_packer verification failed");
    end
    $finish;
  end

endmodule
